/* sv/cpuexe_pkg.sv */
// shared types and constants of the cpu execute unit
`default_nettype none

package cpuexe_pkg;

   // decoded operation codes
   typedef enum logic [3:0] {
      CMD_LD8   = 4'd0,
      CMD_XOR   = 4'd1,
      CMD_ADD   = 4'd2,
      CMD_SUB   = 4'd3,
      CMD_CP    = 4'd4,
      CMD_INC8  = 4'd5,
      CMD_DEC8  = 4'd6,
      CMD_RL    = 4'd7,
      CMD_BIT   = 4'd8,
      CMD_LD16  = 4'd9,
      CMD_INC16 = 4'd10,
      CMD_DEC16 = 4'd11
   } cmd_type;

   // register slot codes
   localparam logic [2:0] SLOT_B   = 3'd0;
   localparam logic [2:0] SLOT_C   = 3'd1;
   localparam logic [2:0] SLOT_D   = 3'd2;
   localparam logic [2:0] SLOT_E   = 3'd3;
   localparam logic [2:0] SLOT_H   = 3'd4;
   localparam logic [2:0] SLOT_L   = 3'd5;
   localparam logic [2:0] SLOT_MEM = 3'd6;
   localparam logic [2:0] SLOT_A   = 3'd7;

   // pair select codes
   localparam logic [1:0] PAIR_BC = 2'd0;
   localparam logic [1:0] PAIR_DE = 2'd1;
   localparam logic [1:0] PAIR_HL = 2'd2;
   localparam logic [1:0] PAIR_SP = 2'd3;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_BITS_W = 53;

   // one decoded operation, last field in the lowest bits
   typedef struct packed {
      logic [2:0]  bit_index;
      logic [1:0]  pair_sel;
      logic [15:0] value;
      logic        src_is_value;
      logic [2:0]  src_reg;
      logic [2:0]  dst_reg;
      cmd_type     cmd;
   } req_type;

   // one result, last field in the lowest bits
   typedef struct packed {
      logic [15:0] pair_value;
      logic [7:0]  accumulator;
      logic        flag_carry;
      logic        flag_half;
      logic        flag_subtract;
      logic        flag_zero;
      logic [15:0] mem_address;
      logic        mem_write;
      logic [7:0]  result_byte;
   } rsp_type;

   typedef struct packed {
      logic z;
      logic n;
      logic h;
      logic c;
   } flags_type;

   // architectural state
   typedef struct packed {
      logic [7:0]  b;
      logic [7:0]  c;
      logic [7:0]  d;
      logic [7:0]  e;
      logic [7:0]  h;
      logic [7:0]  l;
      logic [7:0]  a;
      logic [15:0] sp;
      flags_type   flags;
   } state_type;

endpackage

`default_nettype wire

/* sv/cpuexe_regfile.sv */
// register file, stack pointer and flag register
`default_nettype none

module cpuexe_regfile (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire cpuexe_pkg::state_type state_in,
   output cpuexe_pkg::state_type      state_out
);

   cpuexe_pkg::state_type state_ff;

   // whole state updates when an item leaves the execute stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (wr_en) begin
         state_ff <= state_in;
      end
   end

   assign state_out = state_ff;

endmodule

`default_nettype wire

/* sv/cpuexe_alu.sv */
// combinational alu: one operation against the current state
`default_nettype none

module cpuexe_alu (
   input  wire cpuexe_pkg::req_type   req,
   input  wire cpuexe_pkg::state_type state_cur,
   output cpuexe_pkg::rsp_type        rsp,
   output cpuexe_pkg::state_type      state_nxt
);

   // read an 8-bit slot; the memory slot never reaches here
   function automatic logic [7:0] slot_get(cpuexe_pkg::state_type s, logic [2:0] slot);
      logic [7:0] v;
      case (slot)
         cpuexe_pkg::SLOT_B: v = s.b;
         cpuexe_pkg::SLOT_C: v = s.c;
         cpuexe_pkg::SLOT_D: v = s.d;
         cpuexe_pkg::SLOT_E: v = s.e;
         cpuexe_pkg::SLOT_H: v = s.h;
         cpuexe_pkg::SLOT_L: v = s.l;
         cpuexe_pkg::SLOT_A: v = s.a;
         default:            v = 8'h00;
      endcase
      return v;
   endfunction

   function automatic cpuexe_pkg::state_type slot_set(cpuexe_pkg::state_type s,
                                                      logic [2:0] slot, logic [7:0] v);
      cpuexe_pkg::state_type r;
      r = s;
      case (slot)
         cpuexe_pkg::SLOT_B: r.b = v;
         cpuexe_pkg::SLOT_C: r.c = v;
         cpuexe_pkg::SLOT_D: r.d = v;
         cpuexe_pkg::SLOT_E: r.e = v;
         cpuexe_pkg::SLOT_H: r.h = v;
         cpuexe_pkg::SLOT_L: r.l = v;
         cpuexe_pkg::SLOT_A: r.a = v;
         default:            r = s;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] pair_get(cpuexe_pkg::state_type s, logic [1:0] sel);
      logic [15:0] v;
      case (sel)
         cpuexe_pkg::PAIR_BC: v = {s.b, s.c};
         cpuexe_pkg::PAIR_DE: v = {s.d, s.e};
         cpuexe_pkg::PAIR_HL: v = {s.h, s.l};
         default:             v = s.sp;
      endcase
      return v;
   endfunction

   function automatic cpuexe_pkg::state_type pair_set(cpuexe_pkg::state_type s,
                                                      logic [1:0] sel, logic [15:0] v);
      cpuexe_pkg::state_type r;
      r = s;
      case (sel)
         cpuexe_pkg::PAIR_BC: {r.b, r.c} = v;
         cpuexe_pkg::PAIR_DE: {r.d, r.e} = v;
         cpuexe_pkg::PAIR_HL: {r.h, r.l} = v;
         default:             r.sp = v;
      endcase
      return r;
   endfunction

   logic [7:0]  vbyte;
   logic [7:0]  opnd;
   logic [7:0]  old_dst;
   logic [8:0]  sum9;
   logic [4:0]  half5;
   logic [8:0]  diff9;
   logic [15:0] pair_old;
   logic [15:0] pair_new;
   logic [7:0]  res;
   logic        dst_write;
   logic        wide;
   cpuexe_pkg::state_type s;

   // operand selection
   assign vbyte   = req.value[7:0];
   assign opnd    = (req.src_is_value || req.src_reg == cpuexe_pkg::SLOT_MEM)
                    ? vbyte : slot_get(state_cur, req.src_reg);
   assign old_dst = (req.dst_reg == cpuexe_pkg::SLOT_MEM)
                    ? vbyte : slot_get(state_cur, req.dst_reg);

   // shared arithmetic
   assign sum9     = {1'b0, state_cur.a} + {1'b0, opnd};
   assign half5    = {1'b0, state_cur.a[3:0]} + {1'b0, opnd[3:0]};
   assign diff9    = {1'b0, state_cur.a} - {1'b0, opnd};
   assign pair_old = pair_get(state_cur, req.pair_sel);

   // operation decode and state update
   always_comb begin
      s         = state_cur;
      res       = 8'h00;
      dst_write = 1'b0;
      wide      = 1'b0;
      pair_new  = pair_old;
      case (req.cmd)
         cpuexe_pkg::CMD_LD8: begin
            res       = opnd;
            dst_write = 1'b1;
         end
         cpuexe_pkg::CMD_XOR: begin
            res     = state_cur.a ^ opnd;
            s.a     = res;
            s.flags = '{z: (res == 8'h00), n: 1'b0, h: 1'b0, c: 1'b0};
         end
         cpuexe_pkg::CMD_ADD: begin
            res     = sum9[7:0];
            s.a     = res;
            s.flags = '{z: (res == 8'h00), n: 1'b0, h: half5[4], c: sum9[8]};
         end
         cpuexe_pkg::CMD_SUB, cpuexe_pkg::CMD_CP: begin
            res = diff9[7:0];
            if (req.cmd == cpuexe_pkg::CMD_SUB) begin
               s.a = res;
            end
            s.flags = '{z: (res == 8'h00), n: 1'b1,
                        h: (state_cur.a[3:0] < opnd[3:0]), c: diff9[8]};
         end
         cpuexe_pkg::CMD_INC8: begin
            res       = old_dst + 8'd1;
            dst_write = 1'b1;
            s.flags   = '{z: (res == 8'h00), n: 1'b0, h: (old_dst[3:0] == 4'hF),
                          c: state_cur.flags.c};
         end
         cpuexe_pkg::CMD_DEC8: begin
            res       = old_dst - 8'd1;
            dst_write = 1'b1;
            s.flags   = '{z: (res == 8'h00), n: 1'b1, h: (old_dst[3:0] == 4'h0),
                          c: state_cur.flags.c};
         end
         cpuexe_pkg::CMD_RL: begin
            // old carry enters bit 0, old bit 7 becomes carry
            res       = {old_dst[6:0], state_cur.flags.c};
            dst_write = 1'b1;
            s.flags   = '{z: (res == 8'h00), n: 1'b0, h: 1'b0, c: old_dst[7]};
         end
         cpuexe_pkg::CMD_BIT: begin
            res     = opnd;
            s.flags = '{z: !opnd[req.bit_index], n: 1'b0, h: 1'b1, c: state_cur.flags.c};
         end
         cpuexe_pkg::CMD_LD16: begin
            wide     = 1'b1;
            pair_new = req.value;
         end
         cpuexe_pkg::CMD_INC16: begin
            wide     = 1'b1;
            pair_new = pair_old + 16'd1;
         end
         cpuexe_pkg::CMD_DEC16: begin
            wide     = 1'b1;
            pair_new = pair_old - 16'd1;
         end
         default: begin
            s = state_cur;
         end
      endcase
      if (dst_write && req.dst_reg != cpuexe_pkg::SLOT_MEM) begin
         s = slot_set(s, req.dst_reg, res);
      end
      if (wide) begin
         s = pair_set(s, req.pair_sel, pair_new);
      end
   end

   assign state_nxt = s;

   // result fields
   assign rsp.result_byte   = res;
   assign rsp.mem_write     = dst_write && (req.dst_reg == cpuexe_pkg::SLOT_MEM);
   assign rsp.mem_address   = {state_cur.h, state_cur.l};
   assign rsp.flag_zero     = s.flags.z;
   assign rsp.flag_subtract = s.flags.n;
   assign rsp.flag_half     = s.flags.h;
   assign rsp.flag_carry    = s.flags.c;
   assign rsp.accumulator   = s.a;
   assign rsp.pair_value    = wide ? pair_new : 16'h0000;

endmodule

`default_nettype wire

/* sv/cpu_regfile_alu_execute_top.sv */
// an accepted request enters the input register, then its result is registered in the result register
// throughput: one item per cycle while the result side does not stall, set by the combinational alu and state update
// the input register holds an item while the result register waits to be taken
// reset (synchronous): registers, stack pointer and flags cleared, both stages empty
// state is read and updated as an item moves from input register to result register
`default_nettype none

module cpu_regfile_alu_execute_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // cmd, dst_reg, src_reg, src_is_value, value, pair_sel, bit_index
   input  wire logic [cpuexe_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // result_byte, mem_write, mem_address, flag_zero, flag_subtract, flag_half,
   // flag_carry, accumulator, pair_value, zero fill
   output logic [cpuexe_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   logic                  in_valid_ff;
   cpuexe_pkg::req_type   in_req_ff;
   logic                  out_valid_ff;
   cpuexe_pkg::rsp_type   out_rsp_ff;
   logic                  advance;
   cpuexe_pkg::state_type state_cur;
   cpuexe_pkg::state_type state_nxt;
   cpuexe_pkg::rsp_type   rsp_in;

   // pipeline handshake
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_req_ff <= cpuexe_pkg::req_type'(req_tdata);
      end
   end

   cpuexe_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (advance),
      .state_in  (state_nxt),
      .state_out (state_cur)
   );

   cpuexe_alu u_alu (
      .req       (in_req_ff),
      .state_cur (state_cur),
      .rsp       (rsp_in),
      .state_nxt (state_nxt)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(cpuexe_pkg::RSP_DATA_W - cpuexe_pkg::RSP_BITS_W){1'b0}}, out_rsp_ff};

endmodule

`default_nettype wire

/* sv/cpuexe_checker.sv */
// port-level checks of the execute unit and their binding
`default_nettype none

module cpuexe_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [cpuexe_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // a stalled result keeps its item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // an accepted request is followed by a valid result
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> ##1 rsp_tvalid)
      else $error("result missing after accepted request");

   // a memory write never comes with a pair value
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tdata[52:37] == 16'h0000)
      else $error("memory write with nonzero pair value");

endmodule

bind cpu_regfile_alu_execute_top cpuexe_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

/* verif/cpu_regfile_alu_execute_top_test.sv */
// self-checking stream testbench for the cpu register file and alu execute unit
`timescale 1ns / 1ps

module cpu_regfile_alu_execute_top_test;

   // register file indexes: b, c, d, e, h, l, a
   localparam int IX_H = 4;
   localparam int IX_L = 5;
   localparam int IX_A = 6;
   // command codes the block leaves unused
   localparam logic [3:0] CMD_SPARE_FIRST = 4'd12;
   localparam logic [3:0] CMD_SPARE_LAST  = 4'd15;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD    = 40;
   localparam int CYCLE_LIMIT  = 200000;

   logic                             clock;
   logic                             reset;
   logic                             req_tvalid;
   logic                             req_tready;
   logic [cpuexe_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                             rsp_tvalid;
   logic                             rsp_tready;
   logic [cpuexe_pkg::RSP_DATA_W-1:0] rsp_tdata;

   // mirror of the architectural state
   logic [7:0]            regs [0:6];
   logic [15:0]           sp_now;
   cpuexe_pkg::flags_type flags_now;

   cpuexe_pkg::rsp_type awaited_outcomes [$];
   int      fail_count   = 0;
   int      cycle_count  = 0;
   int      hold_request = 0;
   bit      send_idle    = 1'b0;
   bit      recv_idle    = 1'b0;

   cpu_regfile_alu_execute_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 20 ns clock
   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int slot_ix(input logic [2:0] slot);
      return (slot == cpuexe_pkg::SLOT_A) ? IX_A : int'(slot);
   endfunction

   function automatic logic [15:0] pair_get(input logic [1:0] sel);
      int hi;
      hi = 2 * int'(sel);
      if (sel == cpuexe_pkg::PAIR_SP) return sp_now;
      return {regs[hi], regs[hi + 1]};
   endfunction

   function automatic void pair_set(input logic [1:0] sel, input logic [15:0] v);
      int hi;
      hi = 2 * int'(sel);
      if (sel == cpuexe_pkg::PAIR_SP) begin
         sp_now = v;
      end else begin
         regs[hi]     = v[15:8];
         regs[hi + 1] = v[7:0];
      end
   endfunction

   // executes one operation on the mirror state and returns the outcome
   function automatic cpuexe_pkg::rsp_type execute_op(input cpuexe_pkg::req_type op);
      cpuexe_pkg::rsp_type r;
      logic [15:0] hl;
      logic [7:0]  vbyte;
      logic [7:0]  opnd;
      logic [7:0]  old_dst;
      logic [7:0]  a;
      logic [7:0]  res;
      logic [8:0]  sum;
      logic [4:0]  low_sum;
      logic        cf;
      logic        dst_write;
      logic        wide;
      hl        = {regs[IX_H], regs[IX_L]};
      vbyte     = op.value[7:0];
      opnd      = (op.src_is_value || op.src_reg == cpuexe_pkg::SLOT_MEM)
                  ? vbyte : regs[slot_ix(op.src_reg)];
      old_dst   = (op.dst_reg == cpuexe_pkg::SLOT_MEM) ? vbyte : regs[slot_ix(op.dst_reg)];
      a         = regs[IX_A];
      cf        = flags_now.c;
      res       = 8'h00;
      dst_write = 1'b0;
      wide      = 1'b0;
      case (op.cmd)
         cpuexe_pkg::CMD_LD8: begin
            res       = opnd;
            dst_write = 1'b1;
         end
         cpuexe_pkg::CMD_XOR: begin
            res        = a ^ opnd;
            regs[IX_A] = res;
            flags_now  = '{res == 8'h00, 1'b0, 1'b0, 1'b0};
         end
         cpuexe_pkg::CMD_ADD: begin
            sum        = {1'b0, a} + {1'b0, opnd};
            low_sum    = {1'b0, a[3:0]} + {1'b0, opnd[3:0]};
            res        = sum[7:0];
            regs[IX_A] = res;
            flags_now  = '{res == 8'h00, 1'b0, low_sum[4], sum[8]};
         end
         cpuexe_pkg::CMD_SUB, cpuexe_pkg::CMD_CP: begin
            res = a - opnd;
            if (op.cmd == cpuexe_pkg::CMD_SUB) regs[IX_A] = res;
            flags_now = '{res == 8'h00, 1'b1, a[3:0] < opnd[3:0], a < opnd};
         end
         cpuexe_pkg::CMD_INC8: begin
            res       = old_dst + 8'd1;
            dst_write = 1'b1;
            flags_now = '{res == 8'h00, 1'b0, old_dst[3:0] == 4'hF, cf};
         end
         cpuexe_pkg::CMD_DEC8: begin
            res       = old_dst - 8'd1;
            dst_write = 1'b1;
            flags_now = '{res == 8'h00, 1'b1, old_dst[3:0] == 4'h0, cf};
         end
         cpuexe_pkg::CMD_RL: begin
            res       = {old_dst[6:0], cf};
            dst_write = 1'b1;
            flags_now = '{res == 8'h00, 1'b0, 1'b0, old_dst[7]};
         end
         cpuexe_pkg::CMD_BIT: begin
            res       = opnd;
            flags_now = '{~opnd[op.bit_index], 1'b0, 1'b1, cf};
         end
         cpuexe_pkg::CMD_LD16: begin
            wide = 1'b1;
            pair_set(op.pair_sel, op.value);
         end
         cpuexe_pkg::CMD_INC16: begin
            wide = 1'b1;
            pair_set(op.pair_sel, pair_get(op.pair_sel) + 16'd1);
         end
         cpuexe_pkg::CMD_DEC16: begin
            wide = 1'b1;
            pair_set(op.pair_sel, pair_get(op.pair_sel) - 16'd1);
         end
         default: begin
         end
      endcase
      if (dst_write && op.dst_reg != cpuexe_pkg::SLOT_MEM) regs[slot_ix(op.dst_reg)] = res;
      r.result_byte   = res;
      r.mem_write     = dst_write && (op.dst_reg == cpuexe_pkg::SLOT_MEM);
      r.mem_address   = hl;
      r.flag_zero     = flags_now.z;
      r.flag_subtract = flags_now.n;
      r.flag_half     = flags_now.h;
      r.flag_carry    = flags_now.c;
      r.accumulator   = regs[IX_A];
      r.pair_value    = wide ? pair_get(op.pair_sel) : 16'h0000;
      return r;
   endfunction

   function automatic cpuexe_pkg::req_type make_op(input logic [3:0] cmd,
                                                    input logic [2:0] dst,
                                                    input logic [2:0] src,
                                                    input logic use_val,
                                                    input logic [15:0] value,
                                                    input logic [1:0] sel,
                                                    input logic [2:0] bidx);
      cpuexe_pkg::req_type op;
      op.cmd          = cpuexe_pkg::cmd_type'(cmd);
      op.dst_reg      = dst;
      op.src_reg      = src;
      op.src_is_value = use_val;
      op.value        = value;
      op.pair_sel     = sel;
      op.bit_index    = bidx;
      return op;
   endfunction

   // random operation, loads weighted up so the alu sees varied register contents
   function automatic cpuexe_pkg::req_type rand_op();
      int          pick;
      logic [3:0]  cmd;
      logic [7:0]  lo;
      logic [15:0] val;
      pick = $urandom_range(0, 99);
      if (pick < 20) cmd = cpuexe_pkg::CMD_LD8;
      else if (pick < 28) cmd = cpuexe_pkg::CMD_LD16;
      else if (pick < 95) cmd = 4'($urandom_range(int'(cpuexe_pkg::CMD_XOR),
                                                  int'(cpuexe_pkg::CMD_DEC16)));
      else cmd = 4'($urandom_range(int'(CMD_SPARE_FIRST), int'(CMD_SPARE_LAST)));
      case ($urandom_range(0, 6))
         0:       lo = 8'h00;
         1:       lo = 8'h01;
         2:       lo = 8'h0F;
         3:       lo = 8'h10;
         4:       lo = 8'h7F;
         5:       lo = 8'h80;
         default: lo = 8'hFF;
      endcase
      val = ($urandom_range(0, 1) == 0) ? 16'($urandom) : {8'($urandom), lo};
      if ($urandom_range(0, 15) == 0) val = {lo, lo};
      return make_op(cmd, 3'($urandom), 3'($urandom), $urandom_range(0, 3) == 0, val,
                     2'($urandom), 3'($urandom));
   endfunction

   // offers one item and records its outcome once accepted
   task automatic send_op(input cpuexe_pkg::req_type op);
      int gap;
      gap = send_idle ? $urandom_range(0, 5) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      awaited_outcomes.push_back(execute_op(op));
   endtask

   // stop offering and let every outcome come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (awaited_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %h, got %h", name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_outcome(input cpuexe_pkg::rsp_type got);
      cpuexe_pkg::rsp_type want;
      if (awaited_outcomes.size() == 0) begin
         $error("result with no operation outstanding: %h", got);
         fail_count++;
         return;
      end
      want = awaited_outcomes.pop_front();
      check_field("result_byte", 16'(want.result_byte), 16'(got.result_byte));
      check_field("mem_write", 16'(want.mem_write), 16'(got.mem_write));
      check_field("mem_address", want.mem_address, got.mem_address);
      check_field("flag_zero", 16'(want.flag_zero), 16'(got.flag_zero));
      check_field("flag_subtract", 16'(want.flag_subtract), 16'(got.flag_subtract));
      check_field("flag_half", 16'(want.flag_half), 16'(got.flag_half));
      check_field("flag_carry", 16'(want.flag_carry), 16'(got.flag_carry));
      check_field("accumulator", 16'(want.accumulator), 16'(got.accumulator));
      check_field("pair_value", want.pair_value, got.pair_value);
   endtask

   // result side: random or long hold-off before each item, then check it
   initial begin : result_taker
      int gap;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         gap = recv_idle ? $urandom_range(0, 5) : 0;
         if (hold_request > 0) begin
            gap          = hold_request;
            hold_request = 0;
         end
         @(negedge clock);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         check_outcome(cpuexe_pkg::rsp_type'(rsp_tdata[cpuexe_pkg::RSP_BITS_W-1:0]));
      end
   end

   // run limit
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("cpu_regfile_alu_execute_top test failed");
      $finish;
   end

   // 8-bit and 16-bit loads, memory target and memory source
   task automatic test_loads();
      send_op(make_op(cpuexe_pkg::CMD_LD8, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_B, 1'b1,
                      16'h12FF, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_LD8, cpuexe_pkg::SLOT_B, cpuexe_pkg::SLOT_A, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_LD8, cpuexe_pkg::SLOT_C, cpuexe_pkg::SLOT_D, 1'b1,
                      16'hFF80, cpuexe_pkg::PAIR_DE, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_LD16, cpuexe_pkg::SLOT_B, cpuexe_pkg::SLOT_B, 1'b0,
                      16'hFFFF, cpuexe_pkg::PAIR_HL, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_LD8, cpuexe_pkg::SLOT_MEM, cpuexe_pkg::SLOT_C, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_LD8, cpuexe_pkg::SLOT_D, cpuexe_pkg::SLOT_MEM, 1'b0,
                      16'hA55A, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_LD16, cpuexe_pkg::SLOT_E, cpuexe_pkg::SLOT_E, 1'b0,
                      16'h8001, cpuexe_pkg::PAIR_DE, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_LD8, cpuexe_pkg::SLOT_E, cpuexe_pkg::SLOT_H, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_SP, 3'd0));
      wait_drained();
   endtask

   // xor, add, sub and compare with half carry and carry edges
   task automatic test_alu();
      send_op(make_op(cpuexe_pkg::CMD_XOR, cpuexe_pkg::SLOT_B, cpuexe_pkg::SLOT_A, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_LD8, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_B, 1'b1,
                      16'h000F, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_ADD, cpuexe_pkg::SLOT_C, cpuexe_pkg::SLOT_B, 1'b1,
                      16'h0001, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_ADD, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_B, 1'b1,
                      16'h00F0, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_SUB, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_MEM, 1'b0,
                      16'hFF01, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_CP, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_B, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_XOR, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_C, 1'b1,
                      16'h00FF, cpuexe_pkg::PAIR_BC, 3'd0));
      wait_drained();
   endtask

   // byte increment and decrement keep carry, rotate through carry
   task automatic test_inc_dec_rotate();
      send_op(make_op(cpuexe_pkg::CMD_INC8, cpuexe_pkg::SLOT_MEM, cpuexe_pkg::SLOT_B, 1'b0,
                      16'h00FF, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_DEC8, cpuexe_pkg::SLOT_MEM, cpuexe_pkg::SLOT_B, 1'b0,
                      16'h0010, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_RL, cpuexe_pkg::SLOT_MEM, cpuexe_pkg::SLOT_B, 1'b0,
                      16'h0080, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_RL, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_B, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_DEC8, cpuexe_pkg::SLOT_L, cpuexe_pkg::SLOT_B, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_BC, 3'd0));
      wait_drained();
   endtask

   // bit test, pair wraparound and unused commands
   task automatic test_bit_and_pairs();
      send_op(make_op(cpuexe_pkg::CMD_BIT, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_B, 1'b1,
                      16'h0080, cpuexe_pkg::PAIR_BC, 3'd7));
      send_op(make_op(cpuexe_pkg::CMD_BIT, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_MEM, 1'b0,
                      16'h0080, cpuexe_pkg::PAIR_BC, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_INC16, cpuexe_pkg::SLOT_B, cpuexe_pkg::SLOT_B, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_HL, 3'd0));
      send_op(make_op(cpuexe_pkg::CMD_DEC16, cpuexe_pkg::SLOT_B, cpuexe_pkg::SLOT_B, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_SP, 3'd0));
      send_op(make_op(CMD_SPARE_FIRST, cpuexe_pkg::SLOT_MEM, cpuexe_pkg::SLOT_MEM, 1'b1,
                      16'hFFFF, cpuexe_pkg::PAIR_SP, 3'd7));
      send_op(make_op(CMD_SPARE_LAST, cpuexe_pkg::SLOT_A, cpuexe_pkg::SLOT_A, 1'b0,
                      16'h0000, cpuexe_pkg::PAIR_BC, 3'd0));
      wait_drained();
   endtask

   // random operations, idling switched on and off every few dozen items
   task automatic test_random_mix(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 50 == 0) begin
            send_idle = ($urandom_range(0, 3) != 0);
            recv_idle = ($urandom_range(0, 3) != 0);
         end
         send_op(rand_op());
      end
      wait_drained();
   endtask

   // result side holds off long enough to back up the input
   task automatic test_output_stall();
      send_idle    = 1'b0;
      recv_idle    = 1'b0;
      hold_request = LONG_HOLD;
      repeat (30) send_op(rand_op());
      wait_drained();
   endtask

   // bursts with the sender pausing until everything has come back
   task automatic test_sender_pause();
      send_idle = 1'b1;
      recv_idle = 1'b1;
      repeat (3) begin
         repeat (15) send_op(rand_op());
         wait_drained();
      end
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      for (int i = 0; i < 7; i++) regs[i] = 8'h00;
      sp_now    = 16'h0000;
      flags_now = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_loads();
      test_alu();
      test_inc_dec_rotate();
      test_bit_and_pairs();
      test_random_mix(375);
      test_output_stall();
      test_sender_pause();

      if (fail_count == 0) begin
         $display("cpu_regfile_alu_execute_top test passed");
      end else begin
         $display("cpu_regfile_alu_execute_top test failed");
      end
      $finish;
   end

endmodule
